// ----- hdl/fdtd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, codes and widths of the 1D Yee grid field update block.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  // default grid depth
  localparam int MAX_CELLS_DEF = 1024;

  // field and port widths
  localparam int FIELD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int IDX_W      = 10;
  localparam int CELLS_W    = 11;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 80;

  // update arithmetic
  localparam int FRAC_BITS = 24;
  localparam int MAG_W     = 32;
  localparam int PROD_W    = MAG_W + COEF_W;
  localparam int DELTA_W   = PROD_W - FRAC_BITS + 1;
  localparam int SUM_W     = DELTA_W + 2;

  // cycles between the last sweep issue and its write landing in memory
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_LOADED  = 2'd0,
    STS_STEPPED = 2'd1,
    STS_READ    = 2'd2,
    STS_ERROR   = 2'd3
  } status_t;

  // border kinds
  localparam logic [KIND_W-1:0] BORDER_OPEN = 2'd0;
  localparam logic [KIND_W-1:0] BORDER_PEC  = 2'd1;
  localparam logic [KIND_W-1:0] BORDER_PMC  = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CELLS_IN_USE  = 3'd0,
    CFG_BORDER_LOW    = 3'd1,
    CFG_BORDER_HIGH   = 3'd2,
    CFG_J_SOURCE_CELL = 3'd3,
    CFG_M_SOURCE_CELL = 3'd4,
    CFG_J_SOURCE_EN   = 3'd5,
    CFG_M_SOURCE_EN   = 3'd6
  } cfg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_READ,
    S_SWEEP,
    S_DRAIN,
    S_SRC_RD,
    S_SRC_ADD,
    S_SRC_WR,
    S_BORDER_LO,
    S_BORDER_HI,
    S_RESP
  } state_t;

  // configuration register set
  typedef struct packed {
    logic [CELLS_W-1:0] cells_in_use;
    logic [KIND_W-1:0]  border_low_kind;
    logic [KIND_W-1:0]  border_high_kind;
    logic [IDX_W-1:0]   j_source_cell;
    logic [IDX_W-1:0]   m_source_cell;
    logic               j_source_enable;
    logic               m_source_enable;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic             item_take;
    logic             clear_wr;
    logic             sweep_issue;
    logic             phase_e;
    logic             src_rd;
    logic             src_add;
    logic             src_wr;
    logic             zero_wr;
    logic             load_wr;
    logic             item_rd;
    logic             out_load;
    status_t          resp_status;
    logic [IDX_W-1:0] resp_cell;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ----- hdl/fdtd_ram.sv -----
// ----------------------------------------------------------------------------
// fdtd_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fdtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdtd_ctrl
// Sequencer of the field update: clearing pass, item decode, H and E sweeps,
// source injection, border zeroing and result hand-off.
// ----------------------------------------------------------------------------
module fdtd_ctrl #(
  parameter int MAX_CELLS = fdtd_pkg::MAX_CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fdtd_pkg::cfg_t                 cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fdtd_pkg::OP_W-1:0]      in_op,
  input  logic [fdtd_pkg::IDX_W-1:0]     in_idx,
  input  fdtd_pkg::stat_t                stat,
  output fdtd_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_CELLS)-1:0]   cmd_addr
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int WW = (CW > fdtd_pkg::CELLS_W) ? CW : fdtd_pkg::CELLS_W;

  fdtd_pkg::state_t state_r, state_nxt;
  logic                           phase_r, phase_nxt;
  logic [CW-1:0]                  k_r, k_nxt;
  logic [fdtd_pkg::DRAIN_W-1:0]   drain_r, drain_nxt;
  logic [fdtd_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [fdtd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  fdtd_pkg::status_t              status_r, status_nxt;

  logic [WW-1:0] cells_w, n_w, n_last_w, k_w, idx_w, src_w;
  logic          accept, sweep_last, clear_last, drain_last, idx_ok, src_ok;
  logic          border_lo_hit, border_hi_hit;
  logic [fdtd_pkg::KIND_W-1:0] border_kind;

  // grid size clamped to the usable range
  always_comb begin
    cells_w = WW'(cfg.cells_in_use);
    if (cells_w < WW'(2)) begin
      n_w = WW'(2);
    end else if (cells_w > WW'(MAX_CELLS)) begin
      n_w = WW'(MAX_CELLS);
    end else begin
      n_w = cells_w;
    end
  end

  assign n_last_w   = n_w - WW'(1);
  assign k_w        = WW'(k_r);
  assign idx_w      = WW'(idx_r);
  assign sweep_last = (k_w == n_last_w);
  assign clear_last = (k_w == WW'(MAX_CELLS - 1));
  assign drain_last = (drain_r == fdtd_pkg::DRAIN_W'(fdtd_pkg::DRAIN_CYCLES - 1));
  assign idx_ok     = (idx_w < WW'(MAX_CELLS));
  assign accept     = in_tvalid && in_tready;

  // source of the current phase: M for H, J for E
  assign src_w  = phase_r ? WW'(cfg.j_source_cell) : WW'(cfg.m_source_cell);
  assign src_ok = (phase_r ? cfg.j_source_enable : cfg.m_source_enable) && (src_w < n_w);

  // conductor kind that zeroes the field of this phase
  assign border_kind   = phase_r ? fdtd_pkg::BORDER_PEC : fdtd_pkg::BORDER_PMC;
  assign border_lo_hit = (cfg.border_low_kind == border_kind);
  assign border_hi_hit = (cfg.border_high_kind == border_kind);

  // next state
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    k_nxt      = k_r;
    drain_nxt  = drain_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    unique case (state_r)
      fdtd_pkg::S_CLEAR: begin
        k_nxt = k_r + CW'(1);
        if (clear_last) begin
          state_nxt = fdtd_pkg::S_IDLE;
        end
      end
      fdtd_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          idx_nxt   = in_idx;
          state_nxt = fdtd_pkg::S_DECODE;
        end
      end
      fdtd_pkg::S_DECODE: begin
        case (op_r)
          fdtd_pkg::OP_STEP: begin
            phase_nxt = 1'b0;
            k_nxt     = '0;
            state_nxt = fdtd_pkg::S_SWEEP;
          end
          fdtd_pkg::OP_LOAD: begin
            if (idx_ok) begin
              state_nxt = fdtd_pkg::S_LOAD;
            end else begin
              status_nxt = fdtd_pkg::STS_ERROR;
              state_nxt  = fdtd_pkg::S_RESP;
            end
          end
          fdtd_pkg::OP_READ: begin
            if (idx_ok) begin
              state_nxt = fdtd_pkg::S_READ;
            end else begin
              status_nxt = fdtd_pkg::STS_ERROR;
              state_nxt  = fdtd_pkg::S_RESP;
            end
          end
          default: begin
            status_nxt = fdtd_pkg::STS_ERROR;
            state_nxt  = fdtd_pkg::S_RESP;
          end
        endcase
      end
      fdtd_pkg::S_LOAD: begin
        status_nxt = fdtd_pkg::STS_LOADED;
        state_nxt  = fdtd_pkg::S_RESP;
      end
      fdtd_pkg::S_READ: begin
        status_nxt = fdtd_pkg::STS_READ;
        state_nxt  = fdtd_pkg::S_RESP;
      end
      fdtd_pkg::S_SWEEP: begin
        k_nxt = k_r + CW'(1);
        if (sweep_last) begin
          drain_nxt = '0;
          state_nxt = fdtd_pkg::S_DRAIN;
        end
      end
      fdtd_pkg::S_DRAIN: begin
        drain_nxt = drain_r + fdtd_pkg::DRAIN_W'(1);
        if (drain_last) begin
          state_nxt = src_ok ? fdtd_pkg::S_SRC_RD : fdtd_pkg::S_BORDER_LO;
        end
      end
      fdtd_pkg::S_SRC_RD:    state_nxt = fdtd_pkg::S_SRC_ADD;
      fdtd_pkg::S_SRC_ADD:   state_nxt = fdtd_pkg::S_SRC_WR;
      fdtd_pkg::S_SRC_WR:    state_nxt = fdtd_pkg::S_BORDER_LO;
      fdtd_pkg::S_BORDER_LO: state_nxt = fdtd_pkg::S_BORDER_HI;
      fdtd_pkg::S_BORDER_HI: begin
        if (phase_r) begin
          status_nxt = fdtd_pkg::STS_STEPPED;
          state_nxt  = fdtd_pkg::S_RESP;
        end else begin
          phase_nxt = 1'b1;
          k_nxt     = '0;
          state_nxt = fdtd_pkg::S_SWEEP;
        end
      end
      fdtd_pkg::S_RESP: begin
        if (!stat.out_busy) begin
          state_nxt = fdtd_pkg::S_IDLE;
        end
      end
      default: state_nxt = fdtd_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd             = '0;
    cmd.phase_e     = phase_r;
    cmd.resp_status = status_r;
    cmd.resp_cell   = (status_r == fdtd_pkg::STS_STEPPED) ? '0 : idx_r;
    cmd_addr        = k_r[AW-1:0];
    in_tready       = 1'b0;
    unique case (state_r)
      fdtd_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
      fdtd_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.item_take = accept;
      end
      fdtd_pkg::S_DECODE: ;
      fdtd_pkg::S_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd_addr    = idx_w[AW-1:0];
      end
      fdtd_pkg::S_READ: begin
        cmd.item_rd = 1'b1;
        cmd_addr    = idx_w[AW-1:0];
      end
      fdtd_pkg::S_SWEEP: cmd.sweep_issue = 1'b1;
      fdtd_pkg::S_DRAIN: ;
      fdtd_pkg::S_SRC_RD: begin
        cmd.src_rd = 1'b1;
        cmd_addr   = src_w[AW-1:0];
      end
      fdtd_pkg::S_SRC_ADD: begin
        cmd.src_add = 1'b1;
        cmd_addr    = src_w[AW-1:0];
      end
      fdtd_pkg::S_SRC_WR: begin
        cmd.src_wr = 1'b1;
        cmd_addr   = src_w[AW-1:0];
      end
      fdtd_pkg::S_BORDER_LO: begin
        cmd.zero_wr = border_lo_hit;
        cmd_addr    = '0;
      end
      fdtd_pkg::S_BORDER_HI: begin
        cmd.zero_wr = border_hi_hit;
        cmd_addr    = n_last_w[AW-1:0];
      end
      fdtd_pkg::S_RESP: cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fdtd_pkg::S_CLEAR;
      phase_r  <= 1'b0;
      k_r      <= '0;
      drain_r  <= '0;
      status_r <= fdtd_pkg::STS_LOADED;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      k_r      <= k_nxt;
      drain_r  <= drain_nxt;
      status_r <= status_nxt;
    end
  end

  // latched item fields
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
  end

endmodule

// ----- hdl/fdtd_dp.sv -----
// ----------------------------------------------------------------------------
// fdtd_dp
// Field datapath: E, H and coefficient memories, the four stage leapfrog
// update pipeline, source adder and the result register.
// ----------------------------------------------------------------------------
module fdtd_dp #(
  parameter int MAX_CELLS = fdtd_pkg::MAX_CELLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fdtd_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_CELLS)-1:0]         cmd_addr,
  output fdtd_pkg::stat_t                      stat,
  input  logic [fdtd_pkg::COEF_W-1:0]          in_eps_coef,
  input  logic [fdtd_pkg::COEF_W-1:0]          in_mu_coef,
  input  logic signed [fdtd_pkg::FIELD_W-1:0]  in_j_source,
  input  logic signed [fdtd_pkg::FIELD_W-1:0]  in_m_source,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // cell_out[9:0], e_value[41:10], h_value[73:42], zero pad
  output logic [fdtd_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [fdtd_pkg::STATUS_W-1:0]        out_tuser
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int FW = fdtd_pkg::FIELD_W;
  localparam int SW = fdtd_pkg::SUM_W;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

  // latched item payload
  logic [fdtd_pkg::COEF_W-1:0] eps_r, mu_r;
  logic signed [FW-1:0]        j_src_r, m_src_r;

  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      eps_r   <= in_eps_coef;
      mu_r    <= in_mu_coef;
      j_src_r <= in_j_source;
      m_src_r <= in_m_source;
    end
  end

  // memory ports
  logic          e_we, h_we, e_re, h_re, eps_re, mu_re;
  logic [AW-1:0] e_waddr, h_waddr, e_raddr, h_raddr, mu_raddr, addr_dec;
  logic [FW-1:0] e_wdata, h_wdata, e_rdata, h_rdata;
  logic [fdtd_pkg::COEF_W-1:0] eps_rdata, mu_rdata;

  // pipeline registers
  logic                              v0_r, upd0_r, v1_r, v2_r, v3_r;
  logic [AW-1:0]                     wa0_r, wa1_r, wa2_r, wa3_r;
  logic                              neg1_r, neg2_r, neg3_r;
  logic [fdtd_pkg::MAG_W-1:0]        mag1_r;
  logic [fdtd_pkg::COEF_W-1:0]       coef1_r;
  logic signed [FW-1:0]              old1_r, old2_r, old3_r, prev_r;
  logic [fdtd_pkg::PROD_W-1:0]       prod2_r;
  logic [fdtd_pkg::DELTA_W-1:0]      delta3_r;
  logic signed [FW-1:0]              src_sum_r;

  logic signed [FW-1:0] cur, old_s, tgt_rdata, src_val, upd_res, src_res;
  logic signed [FW:0]   diff, src_sum_w;
  logic [FW:0]          mag_w;
  logic [fdtd_pkg::COEF_W-1:0] coef_s;
  logic signed [SW-1:0] upd_sum;

  assign addr_dec = cmd_addr - AW'(1);

  // read side: sweeps read the driving field at k and the target at its cell
  assign e_re     = cmd.sweep_issue || cmd.item_rd || (cmd.src_rd && cmd.phase_e);
  assign h_re     = cmd.sweep_issue || cmd.item_rd || (cmd.src_rd && !cmd.phase_e);
  assign eps_re   = cmd.sweep_issue && cmd.phase_e;
  assign mu_re    = cmd.sweep_issue && !cmd.phase_e;
  assign e_raddr  = cmd_addr;
  assign h_raddr  = (cmd.sweep_issue && !cmd.phase_e) ? addr_dec : cmd_addr;
  assign mu_raddr = addr_dec;

  // stage 0: issued sweep slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= cmd.sweep_issue;
    end
  end

  always_ff @(posedge clk) begin
    upd0_r <= (cmd_addr != '0);
    wa0_r  <= cmd.phase_e ? cmd_addr : addr_dec;
  end

  // stage 1: field difference and magnitude
  assign cur    = cmd.phase_e ? $signed(h_rdata) : $signed(e_rdata);
  assign old_s  = cmd.phase_e ? $signed(e_rdata) : $signed(h_rdata);
  assign coef_s = cmd.phase_e ? eps_rdata : mu_rdata;
  assign diff   = {cur[FW-1], cur} - {prev_r[FW-1], prev_r};
  assign mag_w  = diff[FW] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v0_r && upd0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      prev_r <= cur;
    end
    neg1_r  <= diff[FW];
    mag1_r  <= mag_w[fdtd_pkg::MAG_W-1:0];
    old1_r  <= old_s;
    coef1_r <= coef_s;
    wa1_r   <= wa0_r;
  end

  // stage 2: product of magnitude and coefficient
  always_ff @(posedge clk) begin
    prod2_r <= fdtd_pkg::PROD_W'(mag1_r) * fdtd_pkg::PROD_W'(coef1_r);
    neg2_r  <= neg1_r;
    old2_r  <= old1_r;
    wa2_r   <= wa1_r;
  end

  // stage 3: round magnitude to nearest, halves away from zero
  always_ff @(posedge clk) begin
    delta3_r <= fdtd_pkg::DELTA_W'(({1'b0, prod2_r}
                + (fdtd_pkg::PROD_W + 1)'(1 << (fdtd_pkg::FRAC_BITS - 1)))
                >> fdtd_pkg::FRAC_BITS);
    neg3_r   <= neg2_r;
    old3_r   <= old2_r;
    wa3_r    <= wa2_r;
  end

  // stage 4: signed add with saturation, result goes to memory
  always_comb begin
    upd_sum = neg3_r ? (SW'(old3_r) - $signed(SW'(delta3_r)))
                     : (SW'(old3_r) + $signed(SW'(delta3_r)));
    if (upd_sum > SAT_MAX) begin
      upd_res = SAT_MAX[FW-1:0];
    end else if (upd_sum < SAT_MIN) begin
      upd_res = SAT_MIN[FW-1:0];
    end else begin
      upd_res = upd_sum[FW-1:0];
    end
  end

  // source injection, read-modify-write of one cell
  assign tgt_rdata = cmd.phase_e ? $signed(e_rdata) : $signed(h_rdata);
  assign src_val   = cmd.phase_e ? j_src_r : m_src_r;
  assign src_sum_w = {tgt_rdata[FW-1], tgt_rdata} + {src_val[FW-1], src_val};

  always_comb begin
    if (src_sum_w[FW] != src_sum_w[FW-1]) begin
      src_res = src_sum_w[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    end else begin
      src_res = src_sum_w[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.src_add) begin
      src_sum_r <= src_res;
    end
  end

  // write side: clearing pass, pipeline result, source sum or border zero
  always_comb begin
    e_we    = cmd.clear_wr || (cmd.phase_e && (v3_r || cmd.src_wr || cmd.zero_wr));
    h_we    = cmd.clear_wr || (!cmd.phase_e && (v3_r || cmd.src_wr || cmd.zero_wr));
    e_waddr = v3_r ? wa3_r : cmd_addr;
    h_waddr = e_waddr;
    if (v3_r) begin
      e_wdata = upd_res;
    end else if (cmd.src_wr) begin
      e_wdata = src_sum_r;
    end else begin
      e_wdata = '0;
    end
    h_wdata = e_wdata;
  end

  fdtd_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_e_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  fdtd_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_h_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  fdtd_ram #(.WIDTH(fdtd_pkg::COEF_W), .DEPTH(MAX_CELLS)) u_eps_ram (
    .clk(clk), .we(cmd.load_wr), .waddr(cmd_addr), .wdata(eps_r),
    .re(eps_re), .raddr(cmd_addr), .rdata(eps_rdata)
  );

  fdtd_ram #(.WIDTH(fdtd_pkg::COEF_W), .DEPTH(MAX_CELLS)) u_mu_ram (
    .clk(clk), .we(cmd.load_wr), .waddr(cmd_addr), .wdata(mu_r),
    .re(mu_re), .raddr(mu_raddr), .rdata(mu_rdata)
  );

  // result register
  logic                                out_valid_r;
  logic [fdtd_pkg::OUT_DATA_W-1:0]     out_data_r;
  fdtd_pkg::status_t                   out_status_r;
  logic                                is_read;

  assign is_read = (cmd.resp_status == fdtd_pkg::STS_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.resp_status;
      out_data_r   <= {6'd0,
                       is_read ? h_rdata : {FW{1'b0}},
                       is_read ? e_rdata : {FW{1'b0}},
                       cmd.resp_cell};
    end
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_status_r;

endmodule

// ----- hdl/fdtd_1d_field_update.sv -----
// ----------------------------------------------------------------------------
// fdtd_1d_field_update
// One-dimensional Yee grid E/H leapfrog solver with per-cell coefficients.
// ----------------------------------------------------------------------------
// After reset the block zeroes every cell of the E and H memories and accepts
// no item until then. A load or read item passes through the decode state,
// its load or read state and the response state, and the next item is taken
// once the block is back in idle. A step item sweeps the grid twice (H, then
// E), one cell per cycle through a four stage update pipeline, each sweep
// followed by a pipeline drain, a read-modify-write of an enabled source
// inside the grid and the low and high border steps. One item is worked on at
// a time; the next item is taken while the previous result waits in the output
// register, and a new result waits in the block until that register is free.
module fdtd_1d_field_update #(
  parameter int MAX_CELLS = fdtd_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cell_index[9:0], eps_coef_in[41:10], mu_coef_in[73:42],
  // j_source_value[105:74], m_source_value[137:106], zero pad
  input  logic [fdtd_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation[1:0]
  input  logic [fdtd_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cell_out[9:0], e_value[41:10], h_value[73:42], zero pad
  output logic [fdtd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [fdtd_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                               cfg_we,
  input  logic [fdtd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fdtd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_CELLS);

  fdtd_pkg::cfg_t  cfg_r, cfg_nxt;
  fdtd_pkg::cmd_t  cmd;
  fdtd_pkg::stat_t stat;
  logic [AW-1:0]   cmd_addr;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        fdtd_pkg::CFG_CELLS_IN_USE:  cfg_nxt.cells_in_use     = cfg_wdata;
        fdtd_pkg::CFG_BORDER_LOW:    cfg_nxt.border_low_kind  = cfg_wdata[1:0];
        fdtd_pkg::CFG_BORDER_HIGH:   cfg_nxt.border_high_kind = cfg_wdata[1:0];
        fdtd_pkg::CFG_J_SOURCE_CELL: cfg_nxt.j_source_cell    = cfg_wdata[9:0];
        fdtd_pkg::CFG_M_SOURCE_CELL: cfg_nxt.m_source_cell    = cfg_wdata[9:0];
        fdtd_pkg::CFG_J_SOURCE_EN:   cfg_nxt.j_source_enable  = cfg_wdata[0];
        fdtd_pkg::CFG_M_SOURCE_EN:   cfg_nxt.m_source_enable  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // reset values: full grid, open borders, sources off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {fdtd_pkg::CELLS_W'(1024), fdtd_pkg::BORDER_OPEN, fdtd_pkg::BORDER_OPEN,
                fdtd_pkg::IDX_W'(0), fdtd_pkg::IDX_W'(0), 1'b0, 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fdtd_ctrl #(.MAX_CELLS(MAX_CELLS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[9:0]),
    .stat      (stat),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr)
  );

  fdtd_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_addr    (cmd_addr),
    .stat        (stat),
    .in_eps_coef (in_tdata[41:10]),
    .in_mu_coef  (in_tdata[73:42]),
    .in_j_source (in_tdata[105:74]),
    .in_m_source (in_tdata[137:106]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
